/* rtl/hsvrgb_pkg.sv */
`default_nettype none

package hsvrgb_pkg;

  localparam int HUE_BITS       = 16;
  localparam int CHANNEL_BITS   = 8;
  localparam int CHAN_TOP       = (1 << CHANNEL_BITS) - 1;

  // 60 degrees = SECTOR_ODD * 2^SECTOR_TWOS
  localparam int SECTOR_DEGREES = 60;
  localparam int SECTOR_ODD     = 15;
  localparam int SECTOR_TWOS    = 2;
  localparam int SECTOR_BOUNDS  = 7;

  typedef logic [CHANNEL_BITS-1:0] chan_t;

  localparam chan_t CHAN_MAX = '1;

  typedef enum logic [2:0] {
    SECT_0,
    SECT_1,
    SECT_2,
    SECT_3,
    SECT_4,
    SECT_5,
    SECT_6,
    SECT_WHITE
  } sector_t;

  typedef struct packed {
    logic [HUE_BITS-1:0] hue;
    chan_t               saturation;
    chan_t               brightness;
  } hsv_word_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_word_t;

endpackage

`default_nettype wire

/* rtl/hsvrgb_sector.sv */
`default_nettype none

module hsvrgb_sector import hsvrgb_pkg::*; #(
  parameter int HUE_FRAC_BITS = 6,
  localparam int SPAN    = SECTOR_DEGREES << HUE_FRAC_BITS,
  localparam int FN_BITS = $clog2(SPAN + 1)
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         hsv_valid,
  output logic              hsv_stall,
  input  wire hsv_word_t    hsv,
  output logic              sect_valid,
  input  wire logic         sect_stall,
  output sector_t           sector,
  output logic [FN_BITS-1:0] frac,
  output chan_t             saturation,
  output chan_t             brightness
);

  logic [31:0]              hue_wide;
  logic [SECTOR_BOUNDS-1:0] above;
  logic [2:0]               idx;
  logic [31:0]              rem_wide;
  logic [FN_BITS-1:0]       rem;
  logic [FN_BITS-1:0]       frac_next;
  logic                     ready;

  always_comb begin
    hue_wide = 32'(hsv.hue);
    for (int k = 0; k < SECTOR_BOUNDS; k++) begin
      above[k] = hue_wide >= 32'((k + 1) * SPAN);
    end
    idx = '0;
    for (int k = 0; k < SECTOR_BOUNDS; k++) begin
      if (above[k]) begin
        idx = 3'(k + 1);
      end
    end
    rem_wide = hue_wide - 32'(idx * SPAN);
    rem      = FN_BITS'(rem_wide);
    // mirror the fraction in even sectors
    frac_next = idx[0] ? rem : FN_BITS'(SPAN) - rem;
  end

  assign ready     = !sect_valid || !sect_stall;
  assign hsv_stall = !ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sect_valid <= 1'b0;
    end else if (ready) begin
      sect_valid <= hsv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && hsv_valid) begin
      sector     <= sector_t'(idx);
      frac       <= frac_next;
      saturation <= hsv.saturation;
      brightness <= hsv.brightness;
    end
  end

endmodule

`default_nettype wire

/* rtl/hsvrgb_product.sv */
`default_nettype none

module hsvrgb_product import hsvrgb_pkg::*; #(
  parameter int HUE_FRAC_BITS = 6,
  localparam int SPAN      = SECTOR_DEGREES << HUE_FRAC_BITS,
  localparam int FN_BITS   = $clog2(SPAN + 1),
  localparam int MAXD      = CHAN_TOP * SPAN,
  localparam int MAXD_BITS = $clog2(MAXD + 1),
  localparam int PN_BITS   = CHANNEL_BITS + MAXD_BITS,
  localparam int XM_BITS   = 2 * CHANNEL_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                sect_valid,
  output logic                     sect_stall,
  input  wire sector_t             sector,
  input  wire logic [FN_BITS-1:0]  frac,
  input  wire chan_t               saturation,
  input  wire chan_t               brightness,
  output logic                     prod_valid,
  input  wire logic                prod_stall,
  output sector_t                  prod_sector,
  output logic [PN_BITS-1:0]       prod_n,
  output logic [XM_BITS-1:0]       prod_m,
  output chan_t                    prod_value
);

  logic                 a_valid;
  sector_t              a_sector;
  logic [MAXD_BITS-1:0] a_sf;
  logic [XM_BITS-1:0]   a_m;
  chan_t                a_value;

  logic [MAXD_BITS-1:0] sf_next;
  logic [XM_BITS-1:0]   m_next;
  logic [MAXD_BITS-1:0] rest;
  logic [PN_BITS-1:0]   n_next;
  logic [XM_BITS-1:0]   xm_next;
  logic                 ready_a;
  logic                 ready_b;

  always_comb begin
    sf_next = MAXD_BITS'(saturation) * MAXD_BITS'(frac);
    m_next  = XM_BITS'(brightness) * XM_BITS'(CHAN_MAX - saturation);
    rest    = MAXD_BITS'(MAXD) - a_sf;
    n_next  = PN_BITS'(a_value) * PN_BITS'(rest);
    // fold the half-up rounding term into the m dividend
    xm_next = a_m + XM_BITS'(CHAN_TOP / 2);
  end

  assign ready_b    = !prod_valid || !prod_stall;
  assign ready_a    = !a_valid || ready_b;
  assign sect_stall = !ready_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid    <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      if (ready_a) begin
        a_valid <= sect_valid;
      end
      if (ready_b) begin
        prod_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && sect_valid) begin
      a_sector <= sector;
      a_sf     <= sf_next;
      a_m      <= m_next;
      a_value  <= brightness;
    end
    if (ready_b && a_valid) begin
      prod_sector <= a_sector;
      prod_n      <= n_next;
      prod_m      <= xm_next;
      prod_value  <= a_value;
    end
  end

endmodule

`default_nettype wire

/* rtl/hsvrgb_divide.sv */
`default_nettype none

module hsvrgb_divide import hsvrgb_pkg::*; #(
  parameter int HUE_FRAC_BITS = 6,
  localparam int SPAN      = SECTOR_DEGREES << HUE_FRAC_BITS,
  localparam int MAXD      = CHAN_TOP * SPAN,
  localparam int MAXD_BITS = $clog2(MAXD + 1),
  localparam int PN_BITS   = CHANNEL_BITS + MAXD_BITS,
  localparam int XM_BITS   = 2 * CHANNEL_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               prod_valid,
  output logic                    prod_stall,
  input  wire sector_t            prod_sector,
  input  wire logic [PN_BITS-1:0] prod_n,
  input  wire logic [XM_BITS-1:0] prod_m,
  input  wire chan_t              prod_value,
  output logic                    quot_valid,
  input  wire logic               quot_stall,
  output sector_t                 quot_sector,
  output chan_t                   quot_n,
  output chan_t                   quot_m,
  output chan_t                   quot_value
);

  localparam int NUM_BITS   = PN_BITS + 2;
  localparam int PRE_SHIFT  = HUE_FRAC_BITS + SECTOR_TWOS + 1;
  localparam int DIV_N      = CHAN_TOP * SECTOR_ODD;
  localparam int XN_BITS    = $clog2(DIV_N * (CHAN_TOP + 1));
  localparam int SH_N       = XN_BITS + $clog2(DIV_N);
  localparam int RN_BITS    = XN_BITS + 2;
  localparam int PRODN_BITS = XN_BITS + RN_BITS;
  localparam int DIV_M      = CHAN_TOP;
  localparam int SH_M       = XM_BITS + $clog2(DIV_M);
  localparam int RM_BITS    = XM_BITS + 2;
  localparam int PRODM_BITS = XM_BITS + RM_BITS;

  localparam logic [RN_BITS-1:0] RECIP_N =
    RN_BITS'(((64'd1 << SH_N) + 64'(DIV_N) - 64'd1) / 64'(DIV_N));
  localparam logic [RM_BITS-1:0] RECIP_M =
    RM_BITS'(((64'd1 << SH_M) + 64'(DIV_M) - 64'd1) / 64'(DIV_M));

  logic                  a_valid;
  sector_t               a_sector;
  logic [XN_BITS-1:0]    a_xn;
  logic [PRODM_BITS-1:0] a_pm;
  chan_t                 a_value;

  logic [NUM_BITS-1:0]   num_n;
  logic [XN_BITS-1:0]    xn_next;
  logic [PRODM_BITS-1:0] pm_next;
  logic [PRODN_BITS-1:0] pn_full;
  chan_t                 n_next;
  chan_t                 m_next;
  logic                  ready_a;
  logic                  ready_b;

  always_comb begin
    num_n   = (NUM_BITS'(prod_n) << 1) + NUM_BITS'(MAXD);
    xn_next = XN_BITS'(num_n >> PRE_SHIFT);
    pm_next = PRODM_BITS'(prod_m) * PRODM_BITS'(RECIP_M);
    pn_full = PRODN_BITS'(a_xn) * PRODN_BITS'(RECIP_N);
    n_next  = CHANNEL_BITS'(pn_full >> SH_N);
    m_next  = CHANNEL_BITS'(a_pm >> SH_M);
  end

  assign ready_b    = !quot_valid || !quot_stall;
  assign ready_a    = !a_valid || ready_b;
  assign prod_stall = !ready_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid    <= 1'b0;
      quot_valid <= 1'b0;
    end else begin
      if (ready_a) begin
        a_valid <= prod_valid;
      end
      if (ready_b) begin
        quot_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && prod_valid) begin
      a_sector <= prod_sector;
      a_xn     <= xn_next;
      a_pm     <= pm_next;
      a_value  <= prod_value;
    end
    if (ready_b && a_valid) begin
      quot_sector <= a_sector;
      quot_n      <= n_next;
      quot_m      <= m_next;
      quot_value  <= a_value;
    end
  end

endmodule

`default_nettype wire

/* rtl/hsv_to_rgb_convert.sv */
// channel  dir  handshake              word
// hsv      in   hsv_valid / hsv_stall  hsv_word_t {hue, saturation, brightness}
// rgb      out  rgb_valid / rgb_stall  rgb_word_t {red, green, blue}
//
// One word accepted every clock while hsv_stall is low.
// Six register stages; the reciprocal multiplies of the rounding divides set
// the longest path.
// rst clears the valid bit of every stage; payload registers are not reset.
// A stall holds the output stage; empty stages upstream keep filling, so
// hsv_stall rises only when all six stages are full.

`default_nettype none

module hsv_to_rgb_convert import hsvrgb_pkg::*; #(
  parameter int HUE_FRAC_BITS = 6
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      hsv_valid,
  output logic           hsv_stall,
  input  wire hsv_word_t hsv,
  output logic           rgb_valid,
  input  wire logic      rgb_stall,
  output rgb_word_t      rgb
);

  localparam int SPAN      = SECTOR_DEGREES << HUE_FRAC_BITS;
  localparam int FN_BITS   = $clog2(SPAN + 1);
  localparam int MAXD      = CHAN_TOP * SPAN;
  localparam int MAXD_BITS = $clog2(MAXD + 1);
  localparam int PN_BITS   = CHANNEL_BITS + MAXD_BITS;
  localparam int XM_BITS   = 2 * CHANNEL_BITS;

  logic               sect_valid;
  logic               sect_stall;
  sector_t            sector;
  logic [FN_BITS-1:0] frac;
  chan_t              saturation;
  chan_t              brightness;

  logic               prod_valid;
  logic               prod_stall;
  sector_t            prod_sector;
  logic [PN_BITS-1:0] prod_n;
  logic [XM_BITS-1:0] prod_m;
  chan_t              prod_value;

  logic               quot_valid;
  logic               quot_stall;
  sector_t            quot_sector;
  chan_t              quot_n;
  chan_t              quot_m;
  chan_t              quot_value;

  rgb_word_t          rgb_next;
  logic               ready;

  hsvrgb_sector #(
    .HUE_FRAC_BITS(HUE_FRAC_BITS)
  ) u_sector (
    .clk        (clk),
    .rst        (rst),
    .hsv_valid  (hsv_valid),
    .hsv_stall  (hsv_stall),
    .hsv        (hsv),
    .sect_valid (sect_valid),
    .sect_stall (sect_stall),
    .sector     (sector),
    .frac       (frac),
    .saturation (saturation),
    .brightness (brightness)
  );

  hsvrgb_product #(
    .HUE_FRAC_BITS(HUE_FRAC_BITS)
  ) u_product (
    .clk         (clk),
    .rst         (rst),
    .sect_valid  (sect_valid),
    .sect_stall  (sect_stall),
    .sector      (sector),
    .frac        (frac),
    .saturation  (saturation),
    .brightness  (brightness),
    .prod_valid  (prod_valid),
    .prod_stall  (prod_stall),
    .prod_sector (prod_sector),
    .prod_n      (prod_n),
    .prod_m      (prod_m),
    .prod_value  (prod_value)
  );

  hsvrgb_divide #(
    .HUE_FRAC_BITS(HUE_FRAC_BITS)
  ) u_divide (
    .clk         (clk),
    .rst         (rst),
    .prod_valid  (prod_valid),
    .prod_stall  (prod_stall),
    .prod_sector (prod_sector),
    .prod_n      (prod_n),
    .prod_m      (prod_m),
    .prod_value  (prod_value),
    .quot_valid  (quot_valid),
    .quot_stall  (quot_stall),
    .quot_sector (quot_sector),
    .quot_n      (quot_n),
    .quot_m      (quot_m),
    .quot_value  (quot_value)
  );

  always_comb begin
    case (quot_sector)
      SECT_0, SECT_6: begin
        rgb_next = '{red: quot_value, green: quot_n, blue: quot_m};
      end
      SECT_1: begin
        rgb_next = '{red: quot_n, green: quot_value, blue: quot_m};
      end
      SECT_2: begin
        rgb_next = '{red: quot_m, green: quot_value, blue: quot_n};
      end
      SECT_3: begin
        rgb_next = '{red: quot_m, green: quot_n, blue: quot_value};
      end
      SECT_4: begin
        rgb_next = '{red: quot_n, green: quot_m, blue: quot_value};
      end
      SECT_5: begin
        rgb_next = '{red: quot_value, green: quot_m, blue: quot_n};
      end
      SECT_WHITE: begin
        rgb_next = '{red: CHAN_MAX, green: CHAN_MAX, blue: CHAN_MAX};
      end
      default: begin
        rgb_next = '{red: CHAN_MAX, green: CHAN_MAX, blue: CHAN_MAX};
      end
    endcase
  end

  assign ready      = !rgb_valid || !rgb_stall;
  assign quot_stall = !ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rgb_valid <= 1'b0;
    end else if (ready) begin
      rgb_valid <= quot_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && quot_valid) begin
      rgb <= rgb_next;
    end
  end

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    hsv_stall |-> (rgb_valid && rgb_stall))
    else $error("input stalled while the pipeline has room");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !rgb_valid)
    else $error("result valid straight after reset");

  a_six_cycle_latency: assert property (@(posedge clk) disable iff (rst)
    (hsv_valid && !hsv_stall) ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall
      ##1 !rgb_stall ##1 !rgb_stall |=> rgb_valid)
    else $error("word lost in a free-running pipeline");
`endif

endmodule

`default_nettype wire

/* tb/tb_hsv_to_rgb_convert.sv */
`default_nettype none

module tb_hsv_to_rgb_convert import hsvrgb_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int              FRAC_BITS  = 6;
  localparam longint unsigned SPAN       = 60 << FRAC_BITS;
  localparam longint unsigned TOP        = CHAN_TOP;
  localparam int              HUE_LIMIT  = SECTOR_BOUNDS * (60 << FRAC_BITS) - 1;
  localparam int              DRAIN_WAIT = 12;
  localparam int              MAX_CYCLES = 200000;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      hsv_valid = 1'b0;
  logic      hsv_stall;
  hsv_word_t hsv       = '0;
  logic      rgb_valid;
  logic      rgb_stall = 1'b0;
  rgb_word_t rgb;

  logic      steady    = 1'b0;
  int        stall_left = 0;
  int        failures  = 0;
  int        accepted  = 0;
  int        checked   = 0;
  int        cycles    = 0;
  int        white_seen = 0;

  rgb_word_t pending_rgb[$];

  hsv_to_rgb_convert #(
    .HUE_FRAC_BITS(FRAC_BITS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .hsv_valid(hsv_valid),
    .hsv_stall(hsv_stall),
    .hsv      (hsv),
    .rgb_valid(rgb_valid),
    .rgb_stall(rgb_stall),
    .rgb      (rgb)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic rgb_word_t predict_rgb(hsv_word_t w);
    longint unsigned sec, rem, frac, s, v;
    chan_t     m, n, vv;
    sector_t   sect;
    rgb_word_t c;
    s    = w.saturation;
    v    = w.brightness;
    sec  = w.hue / SPAN;
    rem  = w.hue - sec * SPAN;
    frac = sec[0] ? rem : SPAN - rem;
    m    = chan_t'((2 * v * (TOP - s) + TOP) / (2 * TOP));
    n    = chan_t'((2 * v * (TOP * SPAN - s * frac) + TOP * SPAN) / (2 * TOP * SPAN));
    vv   = chan_t'(v);
    sect = (sec >= SECTOR_BOUNDS) ? SECT_WHITE : sector_t'(sec[2:0]);
    case (sect)
      SECT_0, SECT_6: c = '{red: vv, green: n,  blue: m};
      SECT_1:         c = '{red: n,  green: vv, blue: m};
      SECT_2:         c = '{red: m,  green: vv, blue: n};
      SECT_3:         c = '{red: m,  green: n,  blue: vv};
      SECT_4:         c = '{red: n,  green: m,  blue: vv};
      SECT_5:         c = '{red: vv, green: m,  blue: n};
      default:        c = '{red: CHAN_MAX, green: CHAN_MAX, blue: CHAN_MAX};
    endcase
    return c;
  endfunction

  // drop valid for a burst now and then, then hold the word until taken
  task automatic send_hsv(input logic [15:0] h, input chan_t s, input chan_t v);
    hsv_word_t w;
    w = '{hue: h, saturation: s, brightness: v};
    if (!steady && $urandom_range(0, 3) == 0) begin
      hsv_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    hsv_valid <= 1'b1;
    hsv       <= w;
    do @(posedge clk); while (hsv_stall);
    pending_rgb.push_back(predict_rgb(w));
    accepted++;
    if (h >= HUE_LIMIT + 1) white_seen++;
  endtask

  task automatic drain_rgb();
    hsv_valid <= 1'b0;
    while (pending_rgb.size() != 0) @(posedge clk);
  endtask

  function automatic chan_t pick_chan();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CHAN_MAX;
      default: return chan_t'($urandom);
    endcase
  endfunction

  task automatic test_extremes();
    send_hsv(16'd0,     8'd0,     8'd0);
    send_hsv(16'd0,     CHAN_MAX, CHAN_MAX);
    send_hsv(16'd0,     CHAN_MAX, 8'd0);
    send_hsv(16'd0,     8'd0,     CHAN_MAX);
    send_hsv(16'd1920,  CHAN_MAX, CHAN_MAX);
    send_hsv(16'hFFFF,  CHAN_MAX, CHAN_MAX);
    send_hsv(16'hFFFF,  8'd0,     8'd0);
  endtask

  task automatic test_sectors();
    for (int k = 0; k <= SECTOR_BOUNDS; k++)
      send_hsv(16'(k * SPAN + SPAN / 2), 8'd200, 8'd180);
    send_hsv(16'(SPAN - 1),  8'd255, 8'd128);
    send_hsv(16'(SPAN),      8'd255, 8'd128);
    send_hsv(16'(HUE_LIMIT), 8'd77,  8'd201);
    send_hsv(16'(HUE_LIMIT + 1), 8'd77, 8'd201);
    send_hsv(16'(6 * SPAN),  8'd130, 8'd250);
  endtask

  task automatic test_random(input int count);
    logic [15:0] h;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 7) == 0) h = 16'($urandom);
      else                           h = 16'($urandom_range(0, HUE_LIMIT));
      send_hsv(h, pick_chan(), pick_chan());
      if (i % 250 == 249) drain_rgb();
    end
  endtask

  task automatic test_steady(input int count);
    steady <= 1'b1;
    for (int i = 0; i < count; i++)
      send_hsv(16'($urandom), chan_t'($urandom), chan_t'($urandom));
  endtask

  // receiver: stall in bursts unless the run is in its steady tail
  always @(posedge clk) begin
    if (steady) begin
      rgb_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      rgb_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      rgb_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 4);
    end else begin
      rgb_stall  <= 1'b0;
    end
  end

  always @(posedge clk) begin
    rgb_word_t want;
    if (!rst && rgb_valid && !rgb_stall) begin
      if (pending_rgb.size() == 0) begin
        $error("rgb word with nothing expected: %h", rgb);
        failures++;
      end else begin
        want = pending_rgb.pop_front();
        checked++;
        if (rgb.red !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, rgb.red);
          failures++;
        end
        if (rgb.green !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, rgb.green);
          failures++;
        end
        if (rgb.blue !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, rgb.blue);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == MAX_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_sectors();
    test_random(1000);
    test_steady(150);
    drain_rgb();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_rgb.size() != 0) begin
      $error("%0d rgb words never arrived", pending_rgb.size());
      failures++;
    end
    $display("Sent %0d HSV words over all hue sectors, %0d in the white region.",
             accepted, white_seen);
    $display("Checked %0d RGB words with bursty idling and a steady tail.", checked);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
